// ===== rtl/tmse_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile matrix engine package
// Shared sizes, codes and types for the tile matrix engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

   localparam int DIM       = 16;
   localparam int SPAD_ROWS = 256;
   localparam int ACC_ROWS  = 256;
   localparam int ELEM_BITS = 8;
   localparam int ACC_BITS  = 32;
   localparam int KW        = $clog2(DIM);
   localparam int SUM_BITS  = 2 * ELEM_BITS + KW;
   localparam int SPAD_AW   = $clog2(SPAD_ROWS);
   localparam int ACC_AW    = $clog2(ACC_ROWS);

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_PRELOAD = 2'd1,
      MODE_COMPUTE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS = 2'd1;
   localparam logic [1:0] STATUS_SHAPE  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_ISSUE,
      ST_WR_MERGE,
      ST_RD_ISSUE,
      ST_RD_SELECT,
      ST_PL_ISSUE,
      ST_PL_LOAD,
      ST_CP_ISSUE,
      ST_CP_LOAD,
      ST_CP_STREAM,
      ST_CP_DRAIN,
      ST_CP_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                        valid;
      logic [KW-1:0]               k;
      logic signed [ELEM_BITS-1:0] a;
   } link_type;

   typedef struct packed {
      logic          en;
      logic [KW-1:0] idx;
   } load_type;

endpackage

// ===== rtl/tmse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/tmse_cell.sv =====
// ----------------------------------------------------------------------------
// Tile matrix engine cell
// Holds one column of the stationary tile and accumulates one output sum
// while A elements pass through it to the next cell.
// ----------------------------------------------------------------------------
module tmse_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tmse_pkg::link_type                    link_in,
   output tmse_pkg::link_type                    link_out,
   input  tmse_pkg::load_type                    load,
   input  logic signed [tmse_pkg::ELEM_BITS-1:0] load_value,
   output logic signed [tmse_pkg::SUM_BITS-1:0]  sum
);
   import tmse_pkg::*;

   logic signed [ELEM_BITS-1:0]   b_ff [DIM];
   link_type                      link_ff;
   logic signed [SUM_BITS-1:0]    acc_ff;
   logic signed [2*ELEM_BITS-1:0] prod;
   logic signed [SUM_BITS-1:0]    acc_in;

   assign prod     = link_ff.a * b_ff[link_ff.k];
   assign acc_in   = ((link_ff.k == '0) ? '0 : acc_ff) + SUM_BITS'(prod);
   assign link_out = link_ff;
   assign sum      = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.k <= link_in.k;
      link_ff.a <= link_in.a;
      if (link_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (load.en) begin
         b_ff[load.idx] <= load_value;
      end
   end

endmodule

// ===== rtl/tile_matmul_scratchpad_engine.sv =====
// ----------------------------------------------------------------------------
// Tile matrix engine
// Scratchpad, stationary B tile held in a chain of column cells, and an
// accumulator store; element writes, preloads, tile computes and reads.
// ----------------------------------------------------------------------------
// After reset the engine clears the scratchpad and the accumulator before it
// takes its first word. A write merges one element into its scratchpad row, a
// read selects one accumulator word, a preload reads one scratchpad row per B
// row into the cells, and a compute passes each A row one element a cycle
// into the chain of DIM cells and through to the last one, then writes its
// sums. Errored words go straight to the response. A new word is taken
// while the previous result still waits in the output register.
module tile_matmul_scratchpad_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_mode,
   input  logic [7:0]                            req_row,
   input  logic [3:0]                            req_col,
   input  logic signed [7:0]                     req_value,
   input  logic [7:0]                            req_out_row,
   input  logic [4:0]                            req_src_rows,
   input  logic [4:0]                            req_src_cols,
   input  logic [4:0]                            req_out_rows,
   input  logic [4:0]                            req_out_cols,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_read_value,
   output logic [1:0]                            rsp_status
);
   import tmse_pkg::*;

   state_type                   state_ff, state_in;
   logic [SPAD_AW-1:0]          clr_ff;
   logic [KW-1:0]               r_ff, k_ff;
   logic [7:0]                  row_ff;
   logic [3:0]                  col_ff;
   logic signed [7:0]           val_ff;
   logic [4:0]                  src_rows_ff, src_cols_ff;
   logic [7:0]                  cbase_ff;
   logic [4:0]                  brows_ff, bcols_ff, crows_ff, ccols_ff;
   logic [31:0]                 pend_value_ff;
   logic [1:0]                  pend_status_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_value_ff;
   logic [1:0]                  rsp_status_ff;
   logic [ELEM_BITS-1:0]        a_row_ff [DIM];
   logic [DIM*ACC_BITS-1:0]     old_row_ff;

   logic                        spad_we, acc_we;
   logic [SPAD_AW-1:0]          spad_waddr, spad_raddr;
   logic [ACC_AW-1:0]           acc_waddr, acc_raddr;
   logic [DIM*ELEM_BITS-1:0]    spad_wdata, spad_rdata;
   logic [DIM*ACC_BITS-1:0]     acc_wdata, acc_rdata;

   link_type                    links [DIM+1];
   link_type                    link_head;
   load_type                    load;
   logic signed [ELEM_BITS-1:0] load_values [DIM];
   logic signed [SUM_BITS-1:0]  sums [DIM];
   logic                        chain_done;
   logic                        rsp_load;

   logic [1:0]                  pl_status, cp_status;

   always_comb begin
      pl_status = STATUS_OK;
      if (req_src_rows > 5'(DIM) || req_src_cols > 5'(DIM) ||
          req_out_rows > 5'(DIM) || req_out_cols > 5'(DIM) ||
          ({1'b0, req_row} + {4'b0, req_src_rows}) > 9'(SPAD_ROWS) ||
          ({1'b0, req_out_row} + {4'b0, req_out_rows}) > 9'(ACC_ROWS)) begin
         pl_status = STATUS_BOUNDS;
      end
      cp_status = STATUS_OK;
      if (req_src_rows > 5'(DIM) || req_src_cols > 5'(DIM) ||
          ({1'b0, req_row} + {4'b0, req_src_rows}) > 9'(SPAD_ROWS)) begin
         cp_status = STATUS_BOUNDS;
      end else if (req_src_cols != brows_ff || crows_ff != req_src_rows ||
                   ccols_ff != bcols_ff) begin
         cp_status = STATUS_SHAPE;
      end
   end

   assign chain_done = links[DIM].valid && (links[DIM].k == KW'(DIM - 1));
   assign rsp_load   = !rsp_valid_ff || rsp_ready;
   assign links[0]   = link_head;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SPAD_AW'(SPAD_ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_WRITE:   state_in = ST_WR_ISSUE;
                  MODE_READ:    state_in = ST_RD_ISSUE;
                  MODE_PRELOAD: state_in = (pl_status != STATUS_OK) ? ST_RESP : ST_PL_ISSUE;
                  MODE_COMPUTE: begin
                     if (cp_status != STATUS_OK || req_src_rows == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_CP_ISSUE;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_WR_ISSUE:  state_in = ST_WR_MERGE;
         ST_WR_MERGE:  state_in = ST_RESP;
         ST_RD_ISSUE:  state_in = ST_RD_SELECT;
         ST_RD_SELECT: state_in = ST_RESP;
         ST_PL_ISSUE:  state_in = ST_PL_LOAD;
         ST_PL_LOAD: begin
            state_in = (r_ff == KW'(DIM - 1)) ? ST_RESP : ST_PL_ISSUE;
         end
         ST_CP_ISSUE:  state_in = ST_CP_LOAD;
         ST_CP_LOAD:   state_in = ST_CP_STREAM;
         ST_CP_STREAM: begin
            if (k_ff == KW'(DIM - 1)) state_in = ST_CP_DRAIN;
         end
         ST_CP_DRAIN: begin
            if (chain_done) state_in = ST_CP_WRITE;
         end
         ST_CP_WRITE: begin
            state_in = ({1'b0, r_ff} == crows_ff - 5'd1) ? ST_RESP : ST_CP_ISSUE;
         end
         ST_RESP: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      spad_we    = 1'b0;
      spad_waddr = row_ff;
      spad_wdata = spad_rdata;
      spad_raddr = row_ff;
      acc_we     = 1'b0;
      acc_waddr  = cbase_ff + {4'b0, r_ff};
      acc_wdata  = old_row_ff;
      acc_raddr  = row_ff;
      load.en    = 1'b0;
      load.idx   = r_ff;
      link_head.valid = 1'b0;
      link_head.k     = k_ff;
      link_head.a     = a_row_ff[k_ff];
      for (int c = 0; c < DIM; c++) begin
         load_values[c] = ({1'b0, r_ff} < src_rows_ff && c < int'(src_cols_ff)) ?
                          spad_rdata[c*ELEM_BITS +: ELEM_BITS] : '0;
      end
      case (state_ff)
         ST_CLEAR: begin
            spad_we    = 1'b1;
            spad_waddr = clr_ff;
            spad_wdata = '0;
            acc_we     = 1'b1;
            acc_waddr  = clr_ff;
            acc_wdata  = '0;
         end
         ST_IDLE: req_ready = 1'b1;
         ST_WR_MERGE: begin
            spad_we = 1'b1;
            spad_wdata[col_ff*ELEM_BITS +: ELEM_BITS] = val_ff;
         end
         ST_PL_ISSUE: spad_raddr = row_ff + {4'b0, r_ff};
         ST_PL_LOAD:  load.en = 1'b1;
         ST_CP_ISSUE: begin
            spad_raddr = row_ff + {4'b0, r_ff};
            acc_raddr  = cbase_ff + {4'b0, r_ff};
         end
         ST_CP_STREAM: link_head.valid = 1'b1;
         ST_CP_WRITE: begin
            acc_we = 1'b1;
            for (int c = 0; c < DIM; c++) begin
               if (c < int'(ccols_ff)) begin
                  acc_wdata[c*ACC_BITS +: ACC_BITS] = ACC_BITS'(sums[c]);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cbase_ff     <= '0;
         brows_ff     <= '0;
         bcols_ff     <= '0;
         crows_ff     <= '0;
         ccols_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RESP && rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               if (req_valid && mode_type'(req_mode) == MODE_PRELOAD &&
                   pl_status == STATUS_OK) begin
                  cbase_ff <= req_out_row;
                  brows_ff <= req_src_rows;
                  bcols_ff <= req_src_cols;
                  crows_ff <= req_out_rows;
                  ccols_ff <= req_out_cols;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            row_ff         <= req_row;
            col_ff         <= req_col;
            val_ff         <= req_value;
            src_rows_ff    <= req_src_rows;
            src_cols_ff    <= req_src_cols;
            r_ff           <= '0;
            k_ff           <= '0;
            pend_value_ff  <= '0;
            case (mode_type'(req_mode))
               MODE_PRELOAD: pend_status_ff <= pl_status;
               MODE_COMPUTE: pend_status_ff <= cp_status;
               default:      pend_status_ff <= STATUS_OK;
            endcase
         end
         ST_RD_SELECT: pend_value_ff <= acc_rdata[col_ff*ACC_BITS +: 32];
         ST_PL_LOAD:   r_ff <= r_ff + 1'b1;
         ST_CP_LOAD: begin
            for (int c = 0; c < DIM; c++) begin
               a_row_ff[c] <= spad_rdata[c*ELEM_BITS +: ELEM_BITS];
            end
            old_row_ff <= acc_rdata;
         end
         ST_CP_STREAM: k_ff <= k_ff + 1'b1;
         ST_CP_WRITE:  r_ff <= r_ff + 1'b1;
         ST_RESP: begin
            if (rsp_load) begin
               rsp_value_ff  <= pend_value_ff;
               rsp_status_ff <= pend_status_ff;
            end
         end
         default: ;
      endcase
   end

   tmse_ram #(.WIDTH(DIM*ELEM_BITS), .DEPTH(SPAD_ROWS)) u_spad (
      .clock (clock),
      .we    (spad_we),
      .waddr (spad_waddr),
      .wdata (spad_wdata),
      .raddr (spad_raddr),
      .rdata (spad_rdata)
   );

   tmse_ram #(.WIDTH(DIM*ACC_BITS), .DEPTH(ACC_ROWS)) u_acc (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   for (genvar c = 0; c < DIM; c++) begin : g_cell
      tmse_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .link_in    (links[c]),
         .link_out   (links[c+1]),
         .load       (load),
         .load_value (load_values[c]),
         .sum        (sums[c])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("A result word appeared outside the response state.");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> state_ff == ST_CP_DRAIN)
      else $error("The cell chain finished a row outside the drain state.");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !spad_we && !acc_we)
      else $error("A store was written while the engine was idle.");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_READ) |=> state_ff == ST_RD_ISSUE)
      else $error("An accepted read did not start an accumulator read.");

endmodule

// ===== tb/tile_matmul_scratchpad_engine_checker.sv =====
// ----------------------------------------------------------------------------
// Tile matrix engine checker
// Watches the request and response channels, keeps its own copy of the
// scratchpad, the stationary B tile and the accumulator, works out the
// expected response of every accepted word and compares it field by field.
// ----------------------------------------------------------------------------
module tile_matmul_scratchpad_engine_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_row,
   input  logic [3:0]        req_col,
   input  logic signed [7:0] req_value,
   input  logic [7:0]        req_out_row,
   input  logic [4:0]        req_src_rows,
   input  logic [4:0]        req_src_cols,
   input  logic [4:0]        req_out_rows,
   input  logic [4:0]        req_out_cols,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic signed [31:0] rsp_read_value,
   input  logic [1:0]        rsp_status,
   output int                failures,
   output int                pending,
   output int                responses,
   output int                good_computes
);
   import tmse_pkg::*;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
   } response_type;

   logic signed [ELEM_BITS-1:0] spad_copy [SPAD_ROWS*DIM];
   logic signed [ELEM_BITS-1:0] b_copy [DIM*DIM];
   logic [ACC_BITS-1:0]         acc_copy [ACC_ROWS*DIM];
   int unsigned c_base, b_rows, b_cols, c_rows, c_cols;
   response_type expected_responses [$];

   function automatic response_type predict_response(
      logic [1:0] mode, int unsigned row, int unsigned col, logic signed [7:0] value,
      int unsigned orow, int unsigned sr, int unsigned sc, int unsigned orr,
      int unsigned occ);
      response_type resp;
      logic [ACC_BITS-1:0] sum;
      resp = '0;
      case (mode_type'(mode))
         MODE_WRITE: begin
            if (row >= SPAD_ROWS || col >= DIM) resp.status = STATUS_BOUNDS;
            else spad_copy[row*DIM+col] = value;
         end
         MODE_PRELOAD: begin
            if (sr > DIM || sc > DIM || orr > DIM || occ > DIM ||
                row + sr > SPAD_ROWS || orow + orr > ACC_ROWS) begin
               resp.status = STATUS_BOUNDS;
            end else begin
               c_base = orow; b_rows = sr; b_cols = sc; c_rows = orr; c_cols = occ;
               for (int i = 0; i < DIM*DIM; i++) b_copy[i] = '0;
               for (int r = 0; r < sr; r++)
                  for (int c = 0; c < sc; c++)
                     b_copy[r*DIM+c] = spad_copy[(row+r)*DIM+c];
            end
         end
         MODE_COMPUTE: begin
            if (sr > DIM || sc > DIM || row + sr > SPAD_ROWS) begin
               resp.status = STATUS_BOUNDS;
            end else if (sc != b_rows || c_rows != sr || c_cols != b_cols) begin
               resp.status = STATUS_SHAPE;
            end else begin
               if (c_rows > 0 && c_cols > 0) good_computes++;
               for (int r = 0; r < c_rows; r++) begin
                  if (c_base + r < ACC_ROWS) begin
                     for (int c = 0; c < c_cols; c++) begin
                        sum = '0;
                        for (int k = 0; k < sc; k++)
                           sum += ACC_BITS'(spad_copy[(row+r)*DIM+k] * b_copy[k*DIM+c]);
                        acc_copy[(c_base+r)*DIM+c] = sum;
                     end
                  end
               end
            end
         end
         default: begin
            if (row >= ACC_ROWS || col >= DIM) resp.status = STATUS_BOUNDS;
            else resp.read_value = acc_copy[row*DIM+col];
         end
      endcase
      return resp;
   endfunction

   assign pending = expected_responses.size();

   initial begin
      failures = 0;
      responses = 0;
      good_computes = 0;
      c_base = 0; b_rows = 0; b_cols = 0; c_rows = 0; c_cols = 0;
      for (int i = 0; i < SPAD_ROWS*DIM; i++) spad_copy[i] = '0;
      for (int i = 0; i < ACC_ROWS*DIM; i++) acc_copy[i] = '0;
      for (int i = 0; i < DIM*DIM; i++) b_copy[i] = '0;
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (expected_responses.size() == 0) begin
               failures++;
               $display("%0t: unexpected response, expected none, actual status %0d value %0d",
                        $time, rsp_status, rsp_read_value);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_read_value !== want.read_value) begin
                  failures++;
                  $display("%0t: read value expected %0d, actual %0d",
                           $time, want.read_value, rsp_read_value);
               end
            end
         end
         if (req_valid && req_ready)
            expected_responses.push_back(predict_response(req_mode, req_row, req_col,
               req_value, req_out_row, req_src_rows, req_src_cols, req_out_rows,
               req_out_cols));
      end
   end

endmodule

// ===== tb/tile_matmul_scratchpad_engine_tb.sv =====
// ----------------------------------------------------------------------------
// Tile matrix engine testbench
// Drives directed and random words into the engine, with random gaps on the
// request side and random stalls on the response side, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tile_matmul_scratchpad_engine_tb;
   import tmse_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode = '0;
   logic [7:0]        req_row = '0;
   logic [3:0]        req_col = '0;
   logic signed [7:0] req_value = '0;
   logic [7:0]        req_out_row = '0;
   logic [4:0]        req_src_rows = '0;
   logic [4:0]        req_src_cols = '0;
   logic [4:0]        req_out_rows = '0;
   logic [4:0]        req_out_cols = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]        rsp_status;
   int                failures, pending, responses, good_computes;
   bit                calm = 1'b0;
   int                words_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tile_matmul_scratchpad_engine dut (.*);

   tile_matmul_scratchpad_engine_checker checker_inst (.*);

   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall = $urandom_range(1, 6);
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(int unsigned mode, int unsigned row, int unsigned col,
                            int unsigned value, int unsigned orow, int unsigned sr,
                            int unsigned sc, int unsigned orr, int unsigned occ);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= 2'(mode); req_row <= 8'(row); req_col <= 4'(col);
      req_value <= 8'(value);
      req_out_row <= 8'(orow); req_src_rows <= 5'(sr); req_src_cols <= 5'(sc);
      req_out_rows <= 5'(orr); req_out_cols <= 5'(occ);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_noise();
      send_word($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
   endtask

   // A well-formed sequence: fill B and A, preload, compute, read back.
   task automatic run_tile(int unsigned n, int unsigned k, int unsigned m);
      int unsigned b_row, a_row, c_row;
      b_row = $urandom_range(0, SPAD_ROWS - k);
      a_row = $urandom_range(0, SPAD_ROWS - n);
      c_row = $urandom_range(0, ACC_ROWS - n);
      repeat ($urandom_range(1, 6))
         send_word(MODE_WRITE, b_row + $urandom_range(0, k > 0 ? k - 1 : 0),
                   $urandom_range(0, DIM - 1), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 6))
         send_word(MODE_WRITE, a_row + $urandom_range(0, n > 0 ? n - 1 : 0),
                   $urandom_range(0, DIM - 1), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      send_word(MODE_PRELOAD, b_row, $urandom, $urandom, c_row, k, m, n, m);
      send_word(MODE_COMPUTE, a_row, $urandom, $urandom, $urandom, n, k, $urandom,
                $urandom);
      repeat ($urandom_range(1, 4))
         send_word(MODE_READ, c_row + $urandom_range(0, n > 0 ? n - 1 : 0),
                   $urandom_range(0, DIM - 1), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
   endtask

   initial begin
      int unsigned n, k, m;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Extreme elements, full tile, bounds and shape errors.
      for (int c = 0; c < 2; c++) begin
         send_word(MODE_WRITE, 8'd255, 4'd15, 8'h80, 8'hff, 5'd31, 5'd31, 5'd31, 5'd31);
         send_word(MODE_WRITE, 8'd0, 4'd0, 8'h7f, 8'h00, 5'd0, 5'd0, 5'd0, 5'd0);
      end
      send_word(MODE_WRITE, 8'd240, 4'd15, 8'h80, 0, 0, 0, 0, 0);
      send_word(MODE_WRITE, 8'd224, 4'd15, 8'h80, 0, 0, 0, 0, 0);
      send_word(MODE_PRELOAD, 8'd240, 0, 0, 8'd240, 5'd16, 5'd16, 5'd16, 5'd16);
      send_word(MODE_COMPUTE, 8'd224, 0, 0, 0, 5'd16, 5'd16, 0, 0);
      send_word(MODE_READ, 8'd255, 4'd15, 0, 0, 0, 0, 0, 0);
      send_word(MODE_READ, 8'd240, 4'd15, 0, 0, 0, 0, 0, 0);
      send_word(MODE_COMPUTE, 8'd0, 0, 0, 0, 5'd16, 5'd15, 0, 0);
      send_word(MODE_COMPUTE, 8'd250, 0, 0, 0, 5'd16, 5'd16, 0, 0);
      send_word(MODE_COMPUTE, 8'd0, 0, 0, 0, 5'd17, 5'd16, 0, 0);
      send_word(MODE_PRELOAD, 8'd250, 0, 0, 0, 5'd16, 5'd16, 5'd16, 5'd16);
      send_word(MODE_PRELOAD, 8'd0, 0, 0, 8'd250, 5'd1, 5'd1, 5'd16, 5'd1);
      send_word(MODE_PRELOAD, 8'd0, 0, 0, 0, 5'd1, 5'd17, 5'd1, 5'd1);
      send_word(MODE_PRELOAD, 8'd0, 0, 0, 0, 5'd0, 5'd0, 5'd0, 5'd0);
      send_word(MODE_COMPUTE, 8'd0, 0, 0, 0, 5'd0, 5'd0, 0, 0);
      send_word(MODE_READ, 8'd0, 4'd0, 0, 0, 0, 0, 0, 0);
      while (words_sent < 1800) begin
         if ($urandom_range(0, 4) == 0) begin
            send_noise();
         end else begin
            n = ($urandom_range(0, 9) == 0) ? DIM : $urandom_range(0, 4);
            k = ($urandom_range(0, 9) == 0) ? DIM : $urandom_range(0, 4);
            m = ($urandom_range(0, 9) == 0) ? DIM : $urandom_range(0, 4);
            if (words_sent > 1500) calm = 1'b1;
            run_tile(n, k, m);
         end
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d words with %0d responses checked, %0d non-empty computes.",
               words_sent, responses, good_computes);
      if (failures == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
